// ===== hw/rtl/ultrasonic_echo_ranger_assert.svh =====
// Assertion macros shared by the echo ranger RTL.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UER_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define UER_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define UER_ASSERT(lbl, clk, rst, prop, msg)
`define UER_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ===== hw/rtl/uer_pkg.sv =====
// Types and constants for the ultrasonic echo ranger.
// No dependencies; used by the interfaces and all RTL modules.
`timescale 1ns / 1ps
package uer_pkg;

  localparam int SENSOR_COUNT_DEF = 4;
  localparam int COUNTER_BITS_DEF = 20;

  localparam int SENSOR_W  = 4;
  localparam int LEVELS_W  = 4;
  localparam int DIST_W    = 15;
  localparam int FRAC_W    = 10;
  localparam int TIMEOUT_W = 20;
  localparam int TRIG_W    = 8;
  localparam int GAP_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;

  localparam int DIST_MUL = 17;
  localparam int DIST_DIV = 1000;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [TIMEOUT_W-1:0] RISE_TIMEOUT_RST   = 20'd25000;
  localparam logic [TIMEOUT_W-1:0] WIDTH_SINGLE_RST   = 20'd30000;
  localparam logic [TIMEOUT_W-1:0] WIDTH_SWEEP_RST    = 20'd300000;
  localparam logic [TRIG_W-1:0]    TRIGGER_RST        = 8'd10;
  localparam logic [GAP_W-1:0]     GAP_RST            = 16'd60;

  localparam logic [CFG_IDX_W-1:0] CFG_RISE_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SINGLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SWEEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP          = 3'd4;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] rise_timeout_us;
    logic [TIMEOUT_W-1:0] width_timeout_single_us;
    logic [TIMEOUT_W-1:0] width_timeout_sweep_us;
    logic [TRIG_W-1:0]    trigger_us;
    logic [GAP_W-1:0]     gap_us;
  } cfg_t;

  typedef struct packed {
    logic [LEVELS_W-1:0] trigger_levels;
    logic                busy_res;
    logic                done_res;
    logic                status;
    logic [SENSOR_W-1:0] result_sensor;
    logic [DIST_W-1:0]   distance_cm;
    logic                last_of_run;
  } result_t;

endpackage

// ===== hw/rtl/uer_if.sv =====
// Handshake channel interfaces of the echo ranger: tick samples, results, config writes.
// Depends on uer_pkg for field widths.
`timescale 1ns / 1ps
interface uer_sample_if;
  import uer_pkg::*;
  logic                valid;
  logic                ready;
  logic                start_req;
  logic                func;
  logic [SENSOR_W-1:0] sensor_index;
  logic [LEVELS_W-1:0] echo_levels;
  modport source (output valid, start_req, func, sensor_index, echo_levels, input ready);
  modport sink (input valid, start_req, func, sensor_index, echo_levels, output ready);
endinterface

interface uer_result_if;
  import uer_pkg::*;
  logic                valid;
  logic                ready;
  logic [LEVELS_W-1:0] trigger_levels;
  logic                busy_res;
  logic                done_res;
  logic                status;
  logic [SENSOR_W-1:0] result_sensor;
  logic [DIST_W-1:0]   distance_cm;
  logic                last_of_run;
  modport source (output valid, trigger_levels, busy_res, done_res, status, result_sensor,
                  distance_cm, last_of_run, input ready);
  modport sink (input valid, trigger_levels, busy_res, done_res, status, result_sensor,
                distance_cm, last_of_run, output ready);
endinterface

interface uer_cfg_if;
  import uer_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/uer_skid.sv =====
// Output register with one skid entry for the result channel.
// Depends on uer_pkg for the result type.
`timescale 1ns / 1ps
module uer_skid (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  uer_pkg::result_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output uer_pkg::result_t out_data
);
  import uer_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    fire;
  logic    drain;

  assign in_ready = !skid_valid;
  assign fire     = in_valid && in_ready;
  assign drain    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      out_valid  <= skid_valid || fire;
      skid_valid <= 1'b0;
    end else if (fire) begin
      skid_valid <= 1'b1;
    end
  end

  // A beat that arrives while the output is stalled parks in the skid entry.
  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (fire) begin
        out_data <= in_data;
      end
    end else if (fire) begin
      skid_data <= in_data;
    end
  end

endmodule

// ===== hw/rtl/uer_core.sv =====
// Ranging sequencer: phase state, tick counter and running distance for one sensor run.
// Depends on uer_pkg for the configuration and result types.
`timescale 1ns / 1ps
module uer_core #(
  parameter int SENSOR_COUNT = uer_pkg::SENSOR_COUNT_DEF,
  parameter int COUNTER_BITS = uer_pkg::COUNTER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic                          start_req,
  input  logic                          func,
  input  logic [uer_pkg::SENSOR_W-1:0]  sensor_index,
  input  logic [uer_pkg::LEVELS_W-1:0]  echo_levels,
  input  uer_pkg::cfg_t                 cfg,
  output uer_pkg::result_t              res
);
  import uer_pkg::*;

  localparam int CW = (COUNTER_BITS > TIMEOUT_W) ? COUNTER_BITS : TIMEOUT_W;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};
  localparam logic [SENSOR_W:0] SC = (SENSOR_W + 1)'(SENSOR_COUNT);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG,
    PH_RISE,
    PH_WIDTH,
    PH_GAP
  } phase_t;

  phase_t                  phase, phase_next;
  logic [COUNTER_BITS-1:0] elapsed, elapsed_next, elapsed_inc;
  logic [SENSOR_W-1:0]     current_sensor, current_sensor_next;
  logic                    sweeping, sweeping_next;
  logic [FRAC_W-1:0]       frac, frac_next, frac_inc;
  logic [DIST_W-1:0]       run_cm, run_cm_next, run_cm_inc;

  logic                    inc_ok;
  logic [FRAC_W:0]         frac_sum;
  logic                    frac_wrap;
  logic [LEVELS_W-1:0]     echo_shifted;
  logic                    echo_hi;
  logic [CW-1:0]           elapsed_cmp;
  logic [TIMEOUT_W-1:0]    width_limit;
  logic                    done, status, last;
  logic [SENSOR_W-1:0]     rsensor;
  logic [DIST_W-1:0]       rdist;

  assign inc_ok      = elapsed != CNT_MAX;
  assign elapsed_inc = inc_ok ? elapsed + 1'b1 : elapsed;
  assign elapsed_cmp = CW'(elapsed_inc);

  // The distance follows the width count as 17/1000 per tick: the fraction
  // in thousandths carries into the centimetre count.
  assign frac_sum  = {1'b0, frac} + (FRAC_W + 1)'(DIST_MUL);
  assign frac_wrap = frac_sum >= (FRAC_W + 1)'(DIST_DIV);

  always_comb begin
    frac_inc   = frac;
    run_cm_inc = run_cm;
    if (inc_ok) begin
      frac_inc = frac_wrap ? FRAC_W'(frac_sum - (FRAC_W + 1)'(DIST_DIV)) : frac_sum[FRAC_W-1:0];
      if (frac_wrap && run_cm != DIST_MAX) begin
        run_cm_inc = run_cm + 1'b1;
      end
    end
  end

  assign echo_shifted = echo_levels >> current_sensor;
  assign echo_hi      = echo_shifted[0];
  assign width_limit  = sweeping ? cfg.width_timeout_sweep_us : cfg.width_timeout_single_us;

  always_comb begin
    phase_next          = phase;
    elapsed_next        = elapsed;
    current_sensor_next = current_sensor;
    sweeping_next       = sweeping;
    frac_next           = '0;
    run_cm_next         = '0;
    done                = 1'b0;
    status              = 1'b0;
    last                = 1'b0;
    rsensor             = '0;
    rdist               = '0;
    case (phase)
      PH_IDLE: begin
        if (start_req) begin
          if (!func && {1'b0, sensor_index} >= SC) begin
            done    = 1'b1;
            status  = 1'b1;
            rsensor = sensor_index;
            last    = 1'b1;
          end else begin
            current_sensor_next = func ? '0 : sensor_index;
            sweeping_next       = func;
            phase_next          = PH_TRIG;
            elapsed_next        = '0;
          end
        end
      end
      PH_TRIG: begin
        elapsed_next = elapsed_inc;
        if (elapsed_cmp >= CW'(cfg.trigger_us)) begin
          phase_next   = PH_RISE;
          elapsed_next = '0;
        end
      end
      PH_RISE: begin
        if (echo_hi) begin
          phase_next   = PH_WIDTH;
          elapsed_next = '0;
        end else begin
          elapsed_next = elapsed_inc;
          if (elapsed_cmp > CW'(cfg.rise_timeout_us)) begin
            done         = 1'b1;
            status       = 1'b1;
            rsensor      = current_sensor;
            last         = 1'b1;
            phase_next   = PH_IDLE;
            elapsed_next = '0;
          end
        end
      end
      PH_WIDTH: begin
        elapsed_next = elapsed_inc;
        frac_next    = frac_inc;
        run_cm_next  = run_cm_inc;
        if (!echo_hi) begin
          done    = 1'b1;
          rsensor = current_sensor;
          rdist   = run_cm_inc;
          if (sweeping && ((SENSOR_W + 1)'(current_sensor) + 1'b1) < SC) begin
            phase_next = PH_GAP;
          end else begin
            last       = 1'b1;
            phase_next = PH_IDLE;
          end
          elapsed_next = '0;
        end else if (elapsed_cmp > CW'(width_limit)) begin
          done         = 1'b1;
          status       = 1'b1;
          rsensor      = current_sensor;
          last         = 1'b1;
          phase_next   = PH_IDLE;
          elapsed_next = '0;
        end
      end
      PH_GAP: begin
        elapsed_next = elapsed_inc;
        if (elapsed_cmp >= CW'(cfg.gap_us)) begin
          current_sensor_next = current_sensor + 1'b1;
          phase_next          = PH_TRIG;
          elapsed_next        = '0;
        end
      end
      default: begin
        phase_next   = PH_IDLE;
        elapsed_next = '0;
      end
    endcase
  end

  always_comb begin
    res.trigger_levels = (phase_next == PH_TRIG) ? (LEVELS_W'(1) << current_sensor_next) : '0;
    res.busy_res       = phase_next != PH_IDLE;
    res.done_res       = done;
    res.status         = status;
    res.result_sensor  = rsensor;
    res.distance_cm    = rdist;
    res.last_of_run    = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      elapsed        <= '0;
      current_sensor <= '0;
      sweeping       <= 1'b0;
      frac           <= '0;
      run_cm         <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      elapsed        <= elapsed_next;
      current_sensor <= current_sensor_next;
      sweeping       <= sweeping_next;
      frac           <= frac_next;
      run_cm         <= run_cm_next;
    end
  end

endmodule

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
// Top level of the ultrasonic echo ranger: config registers, sequencer and result buffer.
// Depends on uer_pkg, uer_if, uer_core, uer_skid and the assertion macro header.
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_assert.svh"
// Usage: every beat on the sample channel is one microsecond tick carrying the
// echo pin levels and an optional start request. Every accepted sample beat
// gives exactly one beat on the result channel, with the trigger pin drive,
// the busy flag and, on the tick a sensor finishes, its distance and status.
// A start in single mode ranges one sensor; in sweep mode all sensors in
// turn, with a gap between them, aborting on the first timeout.
// A sample's result beat is registered in the output register, or in the skid
// entry on a stall. Throughput: one sample beat per cycle while the result side
// keeps up; each beat updates the phase, counter and running distance registers.
// The cfg channel writes one register per beat and is always ready; write it
// only while no run is in progress.
// Reset puts the sequencer in idle, loads the register defaults and empties
// the result channel. When the result receiver stalls, one further sample
// beat is held in a skid entry; sample.ready then falls until it drains.
module ultrasonic_echo_ranger #(
  parameter int SENSOR_COUNT = uer_pkg::SENSOR_COUNT_DEF,
  parameter int COUNTER_BITS = uer_pkg::COUNTER_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  uer_sample_if.sink   sample,
  uer_result_if.source result,
  uer_cfg_if.sink      cfg
);
  import uer_pkg::*;

  cfg_t    regs;
  result_t core_res;
  result_t out_data;
  logic    skid_ready;
  logic    fire;

  assign cfg.ready    = 1'b1;
  assign sample.ready = skid_ready;
  assign fire         = sample.valid && skid_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.rise_timeout_us         <= RISE_TIMEOUT_RST;
      regs.width_timeout_single_us <= WIDTH_SINGLE_RST;
      regs.width_timeout_sweep_us  <= WIDTH_SWEEP_RST;
      regs.trigger_us              <= TRIGGER_RST;
      regs.gap_us                  <= GAP_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_RISE_TIMEOUT: regs.rise_timeout_us         <= TIMEOUT_W'(cfg.data);
        CFG_WIDTH_SINGLE: regs.width_timeout_single_us <= TIMEOUT_W'(cfg.data);
        CFG_WIDTH_SWEEP:  regs.width_timeout_sweep_us  <= TIMEOUT_W'(cfg.data);
        CFG_TRIGGER:      regs.trigger_us              <= cfg.data[TRIG_W-1:0];
        CFG_GAP:          regs.gap_us                  <= cfg.data[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  uer_core #(
    .SENSOR_COUNT (SENSOR_COUNT),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .start_req    (sample.start_req),
    .func         (sample.func),
    .sensor_index (sample.sensor_index),
    .echo_levels  (sample.echo_levels),
    .cfg          (regs),
    .res          (core_res)
  );

  uer_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (skid_ready),
    .in_data   (core_res),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

  assign result.trigger_levels = out_data.trigger_levels;
  assign result.busy_res       = out_data.busy_res;
  assign result.done_res       = out_data.done_res;
  assign result.status         = out_data.status;
  assign result.result_sensor  = out_data.result_sensor;
  assign result.distance_cm    = out_data.distance_cm;
  assign result.last_of_run    = out_data.last_of_run;

  // A beat taken while the result side is stalled must occupy the skid entry.
  `UER_ASSERT(a_skid_takes_beat, clk, rst, fire && result.valid && !result.ready |=> !sample.ready, "stalled beat not held in skid entry")
  // The closing result of a run leaves the sequencer idle.
  `UER_NEVER(a_last_ends_run, clk, rst, core_res.done_res && core_res.last_of_run && core_res.busy_res, "run still busy after its last result")
  // A trigger is only ever driven inside a run.
  `UER_NEVER(a_trigger_busy, clk, rst, core_res.trigger_levels != '0 && !core_res.busy_res, "trigger driven while idle")

endmodule
